@@ rtl/vertex_transform_normalize_assert.svh @@
// ----------------------------------------------------------------------------
// vertex_transform_normalize assertion macros
// Shared assertion forms for the vertex transform checker.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_NORMALIZE_ASSERT_SVH
`define VERTEX_TRANSFORM_NORMALIZE_ASSERT_SVH

// clocked assertion, off while reset is low
`define VTN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("vertex_transform_normalize: assertion failed");

// clocked assertion that also holds during reset
`define VTN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vertex_transform_normalize: assertion failed");

`endif

@@ rtl/vtn_pkg.sv @@
// ----------------------------------------------------------------------------
// vtn_pkg
// Constants shared by the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vtn_pkg;

  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned FRONT_LAT  = 6;
  localparam int unsigned DIR_LAT    = FRONT_LAT + SQRT_STEPS + DIV_STEPS;
  localparam int unsigned POS_DELAY  = DIR_LAT - 2;
  localparam int unsigned RAD_W      = 2 * SQRT_STEPS;

  localparam logic [2:0] REG_TRANSFORM_ROW0 = 3'd0;
  localparam logic [2:0] REG_TRANSFORM_ROW1 = 3'd1;
  localparam logic [2:0] REG_TRANSFORM_ROW2 = 3'd2;
  localparam logic [2:0] REG_NORMAL_ROW0    = 3'd3;
  localparam logic [2:0] REG_NORMAL_ROW1    = 3'd4;
  localparam logic [2:0] REG_NORMAL_ROW2    = 3'd5;

  typedef logic [2:0][15:0] vec3_t;
  typedef logic [2:0][47:0] mat3_t;

endpackage

@@ rtl/vtn_isqrt.sv @@
// ----------------------------------------------------------------------------
// vtn_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vtn_isqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [vtn_pkg::RAD_W-1:0]         rad_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [vtn_pkg::SQRT_STEPS-1:0]    root_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import vtn_pkg::*;

  logic [RAD_W-1:0]      rad_q  [SQRT_STEPS];
  logic [34:0]           rem_q  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] root_q [SQRT_STEPS];
  logic [SIDE_W-1:0]     side_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] vld_q;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [RAD_W-1:0]      rad_s;
    logic [34:0]           rem_s;
    logic [SQRT_STEPS-1:0] root_s;
    logic [SIDE_W-1:0]     side_s;
    logic                  vld_s;
    logic [34:0]           rem_n;
    logic [34:0]           trial;

    if (j == 0) begin : g_first
      assign rad_s  = rad_i;
      assign rem_s  = '0;
      assign root_s = '0;
      assign side_s = side_i;
      assign vld_s  = valid_i;
    end else begin : g_next
      assign rad_s  = rad_q[j-1];
      assign rem_s  = rem_q[j-1];
      assign root_s = root_q[j-1];
      assign side_s = side_q[j-1];
      assign vld_s  = vld_q[j-1];
    end

    always_comb begin
      rem_n = {rem_s[32:0], rad_s[RAD_W-1-2*j -: 2]};
      trial = {2'b00, root_s, 2'b01};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= rad_s;
        side_q[j] <= side_s;
        if (rem_n >= trial) begin
          rem_q[j]  <= rem_n - trial;
          root_q[j] <= {root_s[SQRT_STEPS-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_n;
          root_q[j] <= {root_s[SQRT_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_s;
      end
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

@@ rtl/vtn_div.sv @@
// ----------------------------------------------------------------------------
// vtn_div
// Pipelined restoring divider: (a*32768 + r) / (2r), three lanes, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module vtn_div #(
  parameter int unsigned SIDE_W = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [2:0][29:0]               mag_i,
  input  logic [vtn_pkg::SQRT_STEPS-1:0] root_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic [2:0][14:0]               quo_o,
  output logic [SIDE_W-1:0]              side_o
);
  import vtn_pkg::*;

  logic [2:0][32:0]          rem_q  [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] low_q  [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] quo_q  [DIV_STEPS];
  logic [31:0]               den_q  [DIV_STEPS];
  logic [SIDE_W-1:0]         side_q [DIV_STEPS];
  logic [DIV_STEPS-1:0]      vld_q;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [2:0][32:0]          rem_s;
    logic [2:0][DIV_STEPS-1:0] low_s;
    logic [2:0][DIV_STEPS-1:0] quo_s;
    logic [31:0]               den_s;
    logic [SIDE_W-1:0]         side_s;
    logic                      vld_s;
    logic [2:0][32:0]          rem_n;

    if (j == 0) begin : g_first
      logic [2:0][45:0] num;
      for (genvar c = 0; c < 3; c++) begin : g_lane
        assign num[c]   = {1'b0, mag_i[c], 15'd0} + 46'(root_i);
        assign rem_s[c] = {2'b00, num[c][45:15]};
        assign low_s[c] = num[c][14:0];
      end
      assign quo_s  = '0;
      assign den_s  = {root_i, 1'b0};
      assign side_s = side_i;
      assign vld_s  = valid_i;
    end else begin : g_next
      assign rem_s  = rem_q[j-1];
      assign low_s  = low_q[j-1];
      assign quo_s  = quo_q[j-1];
      assign den_s  = den_q[j-1];
      assign side_s = side_q[j-1];
      assign vld_s  = vld_q[j-1];
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        rem_n[c] = {rem_s[c][31:0], low_s[c][DIV_STEPS-1-j]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[j]  <= low_s;
        den_q[j]  <= den_s;
        side_q[j] <= side_s;
        for (int c = 0; c < 3; c++) begin
          if (rem_n[c] >= {1'b0, den_s}) begin
            rem_q[j][c] <= rem_n[c] - {1'b0, den_s};
            quo_q[j][c] <= {quo_s[c][DIV_STEPS-2:0], 1'b1};
          end else begin
            rem_q[j][c] <= rem_n[c];
            quo_q[j][c] <= {quo_s[c][DIV_STEPS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_s;
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign quo_o   = quo_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule

@@ rtl/vtn_dir_unit.sv @@
// ----------------------------------------------------------------------------
// vtn_dir_unit
// Direction path: 3x3 matrix product, magnitude normalize, length and
// per-component divide to a unit vector in Q1.14.
// ----------------------------------------------------------------------------
module vtn_dir_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  vtn_pkg::mat3_t rows_i,
  input  vtn_pkg::vec3_t vec_i,
  output logic           valid_o,
  output vtn_pkg::vec3_t res_o
);
  import vtn_pkg::*;

  localparam int unsigned SQ_SIDE_W = 94;

  logic [5:0] vld_q;

  // stage 1: products
  logic signed [31:0] prod_q [3][3];
  // stage 2: sums
  logic [2:0][31:0]   mag_q;
  logic [2:0]         sgn_q;
  // stage 3: shift amount
  logic [2:0][31:0]   mag3_q;
  logic [2:0]         sgn3_q;
  logic               zero3_q;
  logic               left3_q;
  logic [4:0]         amt3_q;
  // stage 4: shifted
  logic [2:0][29:0]   nmag_q;
  logic [2:0]         sgn4_q;
  logic               zero4_q;
  // stage 5: squares
  logic [2:0][59:0]   sq_q;
  logic [2:0][29:0]   nmag5_q;
  logic [2:0]         sgn5_q;
  logic               zero5_q;
  // stage 6: length squared
  logic [RAD_W-1:0]   len_q;
  logic [2:0][29:0]   nmag6_q;
  logic [2:0]         sgn6_q;
  logic               zero6_q;

  logic [2:0][33:0]   sum_d;
  logic [2:0][33:0]   abs_d;
  logic [31:0]        or_d;
  logic [4:0]         msb_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = 34'(prod_q[i][0]) + 34'(prod_q[i][1]) + 34'(prod_q[i][2]);
      abs_d[i] = sum_d[i][33] ? (34'd0 - sum_d[i]) : sum_d[i];
    end
    or_d  = mag_q[0] | mag_q[1] | mag_q[2];
    msb_d = '0;
    for (int b = 0; b < 32; b++) begin
      if (or_d[b]) msb_d = 5'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[i][k] <= $signed(rows_i[i][16*k +: 16]) * $signed(vec_i[k]);
        end
        mag_q[i] <= abs_d[i][31:0];
        sgn_q[i] <= sum_d[i][33];
      end

      mag3_q  <= mag_q;
      sgn3_q  <= sgn_q;
      zero3_q <= (or_d == '0);
      left3_q <= (msb_d <= 5'd29);
      amt3_q  <= (msb_d <= 5'd29) ? (5'd29 - msb_d) : (msb_d - 5'd29);

      for (int i = 0; i < 3; i++) begin
        nmag_q[i] <= left3_q ? 30'(mag3_q[i] << amt3_q) : 30'(mag3_q[i] >> amt3_q);
      end
      sgn4_q  <= sgn3_q;
      zero4_q <= zero3_q;

      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= 60'(nmag_q[i]) * 60'(nmag_q[i]);
      end
      nmag5_q <= nmag_q;
      sgn5_q  <= sgn4_q;
      zero5_q <= zero4_q;

      len_q   <= RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
      nmag6_q <= nmag5_q;
      sgn6_q  <= sgn5_q;
      zero6_q <= zero5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  logic                  sq_vld;
  logic [SQRT_STEPS-1:0] root;
  logic [SQ_SIDE_W-1:0]  sq_side;
  logic [2:0][29:0]      dv_mag;
  logic [3:0]            dv_side;
  logic                  dv_vld;
  logic [2:0][14:0]      quo;
  logic [3:0]            quo_side;

  vtn_isqrt #(
    .SIDE_W (SQ_SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q[5]),
    .rad_i   (len_q),
    .side_i  ({zero6_q, sgn6_q, nmag6_q}),
    .valid_o (sq_vld),
    .root_o  (root),
    .side_o  (sq_side)
  );

  assign dv_mag  = sq_side[89:0];
  assign dv_side = sq_side[93:90];

  vtn_div #(
    .SIDE_W (4)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (sq_vld),
    .mag_i   (dv_mag),
    .root_i  (root),
    .side_i  (dv_side),
    .valid_o (dv_vld),
    .quo_o   (quo),
    .side_o  (quo_side)
  );

  // side bit 3 marks a zero vector, bits 2:0 the component signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (quo_side[3]) begin
        res_o[i] = '0;
      end else if (quo_side[i]) begin
        res_o[i] = 16'd0 - {1'b0, quo[i]};
      end else begin
        res_o[i] = {1'b0, quo[i]};
      end
    end
  end

  assign valid_o = dv_vld;

endmodule

@@ rtl/vertex_transform_normalize.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_normalize
// Affine position transform plus normal and tangent through a normal matrix,
// renormalized to unit length.
//
//   channel   dir   handshake                  payload
//   s_axis    in    tvalid/tready              tdata: pos, nrm, tan (9 x 16 bits)
//   m_axis    out   tvalid/tready              tdata: out pos, nrm, tan (9 x 16)
//   cfg       in    cfg_valid_i/cfg_ready_o    cfg_index_i 3 bits, cfg_data_i 64 bits
//
// One word per cycle while the output is taken; the path from input to output register
// runs through the 31-stage square root and the 15-stage divider.
// Reset loads the identity into all matrix rows and empties the pipeline.
// The whole pipeline holds when the output word is not taken.
// cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module vertex_transform_normalize (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tan_x, tan_y, tan_z
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_pos_x/y/z, out_nrm_x/y/z, out_tan_x/y/z
  output logic [143:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import vtn_pkg::*;

  logic [2:0][63:0] xform_q;
  mat3_t            nmat_q;
  logic             en;
  logic             out_vld_q;
  logic [143:0]     out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xform_q[0] <= 64'h0000_0000_0000_1000;
      xform_q[1] <= 64'h0000_0000_1000_0000;
      xform_q[2] <= 64'h0000_1000_0000_0000;
      nmat_q[0]  <= 48'h0000_0000_1000;
      nmat_q[1]  <= 48'h0000_1000_0000;
      nmat_q[2]  <= 48'h1000_0000_0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TRANSFORM_ROW0: xform_q[0] <= cfg_data_i;
        REG_TRANSFORM_ROW1: xform_q[1] <= cfg_data_i;
        REG_TRANSFORM_ROW2: xform_q[2] <= cfg_data_i;
        REG_NORMAL_ROW0:    nmat_q[0]  <= cfg_data_i[47:0];
        REG_NORMAL_ROW1:    nmat_q[1]  <= cfg_data_i[47:0];
        REG_NORMAL_ROW2:    nmat_q[2]  <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // position path
  logic signed [31:0] pprod_q [3][3];
  logic signed [15:0] ptrans_q [3];
  logic [2:0][34:0]   pacc_d;
  logic [2:0][22:0]   pshr_d;
  vec3_t              pres_d;
  vec3_t              pres_q;
  vec3_t              pdly_q [POS_DELAY];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pacc_d[i] = 35'(pprod_q[i][0]) + 35'(pprod_q[i][1]) + 35'(pprod_q[i][2])
                + (35'(ptrans_q[i]) <<< 12) + 35'sd2048;
      pshr_d[i] = 23'($signed(pacc_d[i]) >>> 12);
      if ($signed(pshr_d[i]) > 23'sd32767) begin
        pres_d[i] = 16'h7fff;
      end else if ($signed(pshr_d[i]) < -23'sd32768) begin
        pres_d[i] = 16'h8000;
      end else begin
        pres_d[i] = pshr_d[i][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pprod_q[i][k] <= $signed(xform_q[i][16*k +: 16])
                         * $signed(s_axis_tdata[16*k +: 16]);
        end
        ptrans_q[i] <= $signed(xform_q[i][63:48]);
      end
      pres_q    <= pres_d;
      pdly_q[0] <= pres_q;
      for (int s = 1; s < POS_DELAY; s++) begin
        pdly_q[s] <= pdly_q[s-1];
      end
    end
  end

  // direction paths
  logic  nrm_vld;
  logic  tan_vld;
  vec3_t nrm_res;
  vec3_t tan_res;

  vtn_dir_unit u_nrm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .rows_i  (nmat_q),
    .vec_i   (s_axis_tdata[95:48]),
    .valid_o (nrm_vld),
    .res_o   (nrm_res)
  );

  vtn_dir_unit u_tan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .rows_i  (nmat_q),
    .vec_i   (s_axis_tdata[143:96]),
    .valid_o (tan_vld),
    .res_o   (tan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= nrm_vld && tan_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {tan_res, nrm_res, pdly_q[POS_DELAY-1]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ rtl/vtn_checker.sv @@
// ----------------------------------------------------------------------------
// vtn_checker
// Port-level assertions for vertex_transform_normalize.
// ----------------------------------------------------------------------------
`include "vertex_transform_normalize_assert.svh"

module vtn_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic         cfg_ready_i
);

  logic               out_stall;
  logic signed [15:0] nrm_x;
  logic signed [15:0] tan_x;
  logic               nrm_ok;
  logic               tan_ok;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign nrm_x     = m_axis_tdata[63:48];
  assign tan_x     = m_axis_tdata[111:96];
  assign nrm_ok    = (nrm_x >= -16'sd16384) && (nrm_x <= 16'sd16384);
  assign tan_ok    = (tan_x >= -16'sd16384) && (tan_x <= 16'sd16384);

  `VTN_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))
  `VTN_ASSERT(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `VTN_ASSERT(a_unit_range, clk_i, rst_ni, m_axis_tvalid |-> nrm_ok && tan_ok)
  `VTN_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_i)

endmodule

bind vertex_transform_normalize vtn_checker u_vtn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_i   (cfg_ready_o)
);

@@ tb/sv/vertex_transform_normalize_test.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_normalize_test
// Drives vertices through the transform and compares every output word with
// a local predictor: affine position with round-half-up and saturation, and
// normal and tangent through the normal matrix, scaled and renormalized.
// ----------------------------------------------------------------------------
module vertex_transform_normalize_test;
  import vtn_pkg::*;

  localparam int LATENCY = 60;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [63:0]  cfg_data_i;

  logic [63:0]  xform_row [3];
  logic [47:0]  nmat_row [3];
  logic [143:0] expected_q [$];
  int           mismatches;
  int           words_out;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_cycles;
  bit           done;

  vertex_transform_normalize dut (.*);

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic signed [15:0] lane(logic [143:0] w, int k);
    return w[16*k +: 16];
  endfunction

  function automatic logic [47:0] unit_vec(logic [47:0] rows [3], logic [47:0] v3);
    longint     sum [3];
    logic [63:0] mag [3];
    logic [63:0] peak;
    logic [63:0] len2;
    logic [63:0] root;
    logic [63:0] bitv;
    logic [63:0] rem;
    logic [63:0] q;
    logic [47:0] res;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      sum[i] = 0;
      for (int k = 0; k < 3; k++)
        sum[i] += longint'($signed(rows[i][16*k +: 16])) * longint'($signed(v3[16*k +: 16]));
      mag[i] = sum[i] < 0 ? -sum[i] : sum[i];
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) return '0;
    while (peak < (64'd1 << 29)) begin
      peak <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    while (peak >= (64'd1 << 30)) begin
      peak >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    root = 0;
    rem = len2;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 64'd32768 + root) / (2 * root);
      if (sum[i] < 0) q = -q;
      res[16*i +: 16] = q[15:0];
    end
    return res;
  endfunction

  function automatic logic [143:0] transformed_vertex(logic [143:0] vin);
    logic [143:0] vout;
    longint       acc;
    for (int i = 0; i < 3; i++) begin
      acc = longint'($signed(xform_row[i][63:48])) * 4096;
      for (int k = 0; k < 3; k++)
        acc += longint'($signed(xform_row[i][16*k +: 16])) * longint'(lane(vin, k));
      acc = (acc + 2048) >>> 12;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      vout[16*i +: 16] = acc[15:0];
    end
    vout[95:48]  = unit_vec(nmat_row, vin[95:48]);
    vout[143:96] = unit_vec(nmat_row, vin[143:96]);
    return vout;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx <= REG_TRANSFORM_ROW2) xform_row[idx] = val;
    else if (idx <= REG_NORMAL_ROW2) nmat_row[idx - REG_NORMAL_ROW0] = val[47:0];
  endtask

  task automatic send_vertex(logic [143:0] vin);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= vin;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(transformed_vertex(vin));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(33)) - 16);
      3: return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [143:0] rnd_vertex();
    logic [143:0] v;
    for (int k = 0; k < 9; k++) v[16*k +: 16] = rnd_field();
    if ($urandom_range(15) == 0) v[95:48] = '0;
    if ($urandom_range(15) == 0) v[143:96] = '0;
    return v;
  endfunction

  function automatic logic [15:0] rnd_coef();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_random_matrices();
    for (int i = 0; i < 3; i++)
      write_reg(3'(REG_TRANSFORM_ROW0 + i),
                {rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()});
    for (int i = 0; i < 3; i++)
      write_reg(3'(REG_NORMAL_ROW0 + i),
                {rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()});
  endtask

  task automatic test_directed();
    logic [15:0] ext [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    send_vertex('0);
    foreach (ext[a])
      send_vertex({9{ext[a]}});
    send_vertex({48'h0, 48'h0, 16'h0100, 16'hff00, 16'h7fff});
    send_vertex({16'h0, 16'h0, 16'h4000, 16'h0, 16'h0001, 16'h0, 48'h0});
    send_vertex({16'h8000, 16'h7fff, 16'h0001, 16'h0001, 16'hffff, 16'h0, 48'h7fff_8000_7fff});
    drain();
    // extreme coefficients, translation saturating both ways
    write_reg(REG_TRANSFORM_ROW0, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    write_reg(REG_TRANSFORM_ROW1, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_TRANSFORM_ROW2, 64'h0);
    write_reg(REG_NORMAL_ROW0, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    write_reg(REG_NORMAL_ROW1, {16'h0000, 16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_NORMAL_ROW2, 64'h0);
    foreach (ext[a])
      send_vertex({9{ext[a]}});
    send_vertex({16'h0001, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 48'h0001_0000_7fff});
    drain();
    write_reg(3'd6, 64'hffff_ffff_ffff_ffff);
    write_reg(3'd7, 64'h1234_5678_9abc_def0);
    send_vertex({9{16'h1234}});
    drain();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        drain();
        load_random_matrices();
      end
      send_vertex(rnd_vertex());
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 200;
    for (int n = 0; n < 150; n++) send_vertex(rnd_vertex());
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        logic [143:0] exp_w;
        exp_w = expected_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (exp_w[16*k +: 16] !== m_axis_tdata[16*k +: 16]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h, got %h", k,
                       exp_w[16*k +: 16], m_axis_tdata[16*k +: 16]);
          end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mismatches    = 0;
    words_out     = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles   = 0;
    done          = 1'b0;
    for (int i = 0; i < 3; i++) begin
      xform_row[i] = 64'd4096 << (16 * i);
      nmat_row[i]  = 48'd4096 << (16 * i);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500);
    send_idle_pct = 65;
    test_random(500);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    test_random(500);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    test_random(500);
    test_backpressure();
    if (expected_q.size() != 0) mismatches += expected_q.size();
    $display("Checked %0d vertices across identity, extreme and random matrices,", words_out);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    done = 1'b1;
    $finish;
  end

  initial begin
    #3000000;
    if (!done) begin
      $display("Test completed with failures");
      $finish;
    end
  end
endmodule
